// ===== hdl/c3v_pkg.sv =====
// c3v_pkg: types, widths and register codes shared by the 3x3 convolution block
// no dependencies; compiled before every other file of the block

package c3v_pkg;

    localparam int PIX_W          = 8;
    localparam int PROD_W         = 16;
    localparam int ACC_W          = 20;
    localparam int SUM_W          = 19;
    localparam int KSIZE          = 3;
    localparam int TAPS           = KSIZE * KSIZE;
    localparam int KROW_W         = KSIZE * PIX_W;
    localparam int SIZE_W         = 11;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int MIN_SIZE       = 3;
    localparam int FIRST_OUT      = 2;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    typedef logic signed [PIX_W-1:0]  pixel_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [KROW_W-1:0]        krow_t;
    typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;
    typedef logic [TAPS-1:0][PIX_W-1:0]   window_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_IMAGE_HEIGHT   = 3'd1,
        CFG_KERNEL_ROW_TOP = 3'd2,
        CFG_KERNEL_ROW_MID = 3'd3,
        CFG_KERNEL_ROW_BOT = 3'd4
    } cfg_idx_e;

    // new column entering the window
    typedef struct packed {
        logic   shift;
        pixel_t col_top;
        pixel_t col_mid;
        pixel_t col_bot;
    } win_upd_t;

    // item leaving the window stage towards the multipliers
    typedef struct packed {
        logic valid;
        logic last;
    } mac_req_t;

endpackage

// ===== hdl/c3v_stream_if.sv =====
// c3v_pixel_if and c3v_result_if: valid/ready channels of the convolution block
// depends on c3v_pkg

interface c3v_pixel_if;
    import c3v_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface c3v_result_if;
    import c3v_pkg::*;

    logic valid;
    logic ready;
    sum_t conv_sum;
    logic frame_last;

    modport source (output valid, output conv_sum, output frame_last, input ready);
    modport sink (input valid, input conv_sum, input frame_last, output ready);
endinterface

// ===== hdl/c3v_linebuf.sv =====
// c3v_linebuf: the two line memories holding the rows above the current one
// depends on c3v_pkg; read data registered, one read and one write per cycle

module c3v_linebuf #(
    parameter int DEPTH = c3v_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  c3v_pkg::pixel_t wr_pixel,
    output c3v_pkg::pixel_t rd_older,
    output c3v_pkg::pixel_t rd_newer
);
    import c3v_pkg::*;

    logic [PIX_W-1:0] older_mem [DEPTH];
    logic [PIX_W-1:0] newer_mem [DEPTH];
    pixel_t           rd_older_reg;
    pixel_t           rd_newer_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_older_reg <= older_mem[rd_addr];
            rd_newer_reg <= newer_mem[rd_addr];
        end
    end

    // the row above moves down to the older line, the new pixel takes its place
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= rd_newer_reg;
            newer_mem[wr_addr] <= wr_pixel;
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_newer = rd_newer_reg;

endmodule

// ===== hdl/c3v_window.sv =====
// c3v_window: 3x3 pixel window, shifted left by one column per pixel
// depends on c3v_pkg

module c3v_window (
    input  logic              clk,
    input  logic              rst_n,
    input  c3v_pkg::win_upd_t upd,
    output c3v_pkg::window_t  win
);
    import c3v_pkg::*;

    window_t win_reg;
    window_t win_next;

    always_comb
    begin
        win_next = win_reg;
        if (upd.shift)
        begin
            for (int k = 0; k < KSIZE; k++)
            begin
                for (int q = 0; q < KSIZE - 1; q++)
                begin
                    win_next[k * KSIZE + q] = win_reg[k * KSIZE + q + 1];
                end
            end
            win_next[KSIZE - 1]         = upd.col_top;
            win_next[2 * KSIZE - 1]     = upd.col_mid;
            win_next[KSIZE * KSIZE - 1] = upd.col_bot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

// ===== hdl/c3v_mac.sv =====
// c3v_mac: nine weight-times-pixel products, then their sum into the output register
// depends on c3v_pkg and c3v_stream_if

module c3v_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  c3v_pkg::mac_req_t req,
    output logic              req_ready,
    input  c3v_pkg::window_t  win,
    input  c3v_pkg::kernel_t  kernel,
    c3v_result_if.source      res
);
    import c3v_pkg::*;

    logic             s2_valid_reg, s2_valid_next;
    logic             s2_last_reg;
    logic             s3_valid_reg, s3_valid_next;
    logic             s3_last_reg;
    prod_t [TAPS-1:0] prod_reg;
    prod_t [TAPS-1:0] prod_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg;
    sum_t             out_sum_reg;
    acc_t             acc_next;
    logic             out_free;
    logic             s3_free;
    pixel_t           wt;
    pixel_t           px;

    assign out_free  = !out_valid_reg || res.ready;
    assign s3_free   = !s3_valid_reg || out_free;
    assign req_ready = !s2_valid_reg || s3_free;

    always_comb
    begin
        for (int k = 0; k < KSIZE; k++)
        begin
            for (int q = 0; q < KSIZE; q++)
            begin
                wt = kernel[k][PIX_W * q +: PIX_W];
                px = win[k * KSIZE + q];
                prod_next[k * KSIZE + q] = PROD_W'(wt) * PROD_W'(px);
            end
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            acc_next = acc_next + ACC_W'(prod_reg[i]);
        end
    end

    assign s2_valid_next  = req_ready ? req.valid : s2_valid_reg;
    assign s3_valid_next  = s3_free ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = out_free ? s3_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req.valid)
        begin
            s2_last_reg <= req.last;
        end
        if (s3_free && s2_valid_reg)
        begin
            prod_reg    <= prod_next;
            s3_last_reg <= s2_last_reg;
        end
        if (out_free && s3_valid_reg)
        begin
            out_sum_reg  <= acc_next[SUM_W-1:0];
            out_last_reg <= s3_last_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.conv_sum   = out_sum_reg;
    assign res.frame_last = out_last_reg;

endmodule

// ===== hdl/conv3x3_valid_int8.sv =====
// conv3x3_valid_int8: streaming 3x3 valid convolution of signed 8-bit pixels
// depends on c3v_pkg, c3v_stream_if, c3v_linebuf, c3v_window and c3v_mac
//
// pixels enter on pix in raster order, one transfer per valid/ready pair;
// results leave on res, one per pixel that completes a window
// (row and column both at least 2), frame_last set on the last one
// throughput: one pixel per cycle while res is not stalled, bound by the
// single read and write port of each line memory; pixels without a result
// drop out after the window; each result passes the memory read, window
// shift, products and sum into the output register, each step registered
// configuration: cfg_we with cfg_index and cfg_wdata, written while idle;
// a size write restarts the frame, a kernel write applies to later products
// reset: sizes 3 by 3, kernel zero, window zero, counters at the frame start;
// line memories are not cleared; results use only entries already written
// stall: a result held at res stays stable; pixels keep being taken while
// bubbles remain in the pipeline, then pix.ready drops

module conv3x3_valid_int8 #(
    parameter int MAX_WIDTH  = c3v_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3v_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [c3v_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [c3v_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    c3v_pixel_if.sink                       pix,
    c3v_result_if.source                    res
);
    import c3v_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] last_col_reg, last_col_next;
    logic [RW-1:0] last_row_reg, last_row_next;
    kernel_t       kernel_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SIZE_W-1:0] size_req;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    pixel_t        s1_px_reg;
    logic          s1_prod_reg;
    logic          s1_last_reg;

    logic          pix_xfer;
    logic          s1_fire;
    logic          mac_ready;
    logic          at_last_col;
    logic          at_last_row;
    pixel_t        rd_older;
    pixel_t        rd_newer;
    win_upd_t      upd;
    mac_req_t      req;
    window_t       win;

    assign size_req = cfg_wdata[SIZE_W-1:0];

    // clamp the requested size and keep the last column and row index
    always_comb
    begin
        if (size_req < SIZE_W'(MIN_SIZE))
        begin
            last_col_next = CW'(MIN_SIZE - 1);
            last_row_next = RW'(MIN_SIZE - 1);
        end
        else
        begin
            if (size_req > MAX_WIDTH)
            begin
                last_col_next = CW'(MAX_WIDTH - 1);
            end
            else
            begin
                last_col_next = CW'(size_req - SIZE_W'(1));
            end
            if (size_req > MAX_HEIGHT)
            begin
                last_row_next = RW'(MAX_HEIGHT - 1);
            end
            else
            begin
                last_row_next = RW'(size_req - SIZE_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= CW'(MIN_SIZE - 1);
            last_row_reg <= RW'(MIN_SIZE - 1);
            kernel_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:    last_col_reg  <= last_col_next;
                CFG_IMAGE_HEIGHT:   last_row_reg  <= last_row_next;
                CFG_KERNEL_ROW_TOP: kernel_reg[0] <= cfg_wdata[KROW_W-1:0];
                CFG_KERNEL_ROW_MID: kernel_reg[1] <= cfg_wdata[KROW_W-1:0];
                CFG_KERNEL_ROW_BOT: kernel_reg[2] <= cfg_wdata[KROW_W-1:0];
                default:            ;
            endcase
        end
    end

    assign s1_fire   = s1_valid_reg && mac_ready;
    assign pix.ready = !s1_valid_reg || s1_fire;
    assign pix_xfer  = pix.valid && pix.ready;

    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (pix_xfer)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= pix.ready ? pix.valid : s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            s1_col_reg  <= col_reg;
            s1_px_reg   <= pix.pixel;
            s1_prod_reg <= (row_reg >= RW'(FIRST_OUT)) && (col_reg >= CW'(FIRST_OUT));
            s1_last_reg <= at_last_row && at_last_col;
        end
    end

    c3v_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_linebuf (
        .clk      (clk),
        .rd_en    (pix_xfer),
        .rd_addr  (col_reg),
        .wr_en    (s1_fire),
        .wr_addr  (s1_col_reg),
        .wr_pixel (s1_px_reg),
        .rd_older (rd_older),
        .rd_newer (rd_newer)
    );

    assign upd.shift   = s1_fire;
    assign upd.col_top = rd_older;
    assign upd.col_mid = rd_newer;
    assign upd.col_bot = s1_px_reg;

    c3v_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .win   (win)
    );

    assign req.valid = s1_fire && s1_prod_reg;
    assign req.last  = s1_last_reg;

    c3v_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (mac_ready),
        .win       (win),
        .kernel    (kernel_reg),
        .res       (res)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_col_reg) && (row_reg <= last_row_reg))
        else $error("frame position beyond the configured size");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_xfer && at_last_col && at_last_row && !cfg_we) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not return to the frame start");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && pix_xfer) |-> (s1_col_reg != col_reg))
        else $error("line memory read and write at the same column");

endmodule

// ===== dv/c3v_sum_checker.sv =====
`timescale 1ns / 100ps
// c3v_sum_checker: watches the register, pixel and result ports of the 3x3 convolution
// and compares every result transfer with its own raster model of the block
// depends on c3v_pkg and on the c3v_pixel_if and c3v_result_if interfaces

module c3v_sum_checker #(
    parameter int MAX_WIDTH  = c3v_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3v_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [c3v_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [c3v_pkg::CFG_DATA_W-1:0] cfg_wdata,
    c3v_pixel_if                           pix,
    c3v_result_if                          res,
    output int                             mismatches,
    output int                             sums_outstanding,
    output int                             sums_checked,
    output int                             frames_closed
);
    import c3v_pkg::*;

    typedef struct packed {
        sum_t conv_sum;
        logic frame_last;
    } conv_result_t;

    conv_result_t      sums_due [$];
    logic [SIZE_W-1:0] width_cfg;
    logic [SIZE_W-1:0] height_cfg;
    kernel_t           weights;
    pixel_t            line_two_up [MAX_WIDTH];
    pixel_t            line_one_up [MAX_WIDTH];
    pixel_t            win [TAPS];
    int                col_pos;
    int                row_pos;
    int                errors;
    int                checked;
    int                frames;

    function automatic int size_in_use(input logic [SIZE_W-1:0] v, input int limit);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // shift one pixel into the window and line stores, queue the sum it completes
    task automatic slide_and_sum(input pixel_t px);
        int           w;
        int           h;
        int           c;
        int           r;
        int           k;
        int           q;
        int           acc;
        pixel_t       wt;
        conv_result_t due;
        w = size_in_use(width_cfg, MAX_WIDTH);
        h = size_in_use(height_cfg, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        for (k = 0; k < KSIZE; k++)
        begin
            win[k*KSIZE]     = win[k*KSIZE + 1];
            win[k*KSIZE + 1] = win[k*KSIZE + 2];
        end
        win[2]         = line_two_up[c];
        win[5]         = line_one_up[c];
        win[8]         = px;
        line_two_up[c] = line_one_up[c];
        line_one_up[c] = px;
        if (r >= FIRST_OUT && c >= FIRST_OUT)
        begin
            acc = 0;
            for (k = 0; k < KSIZE; k++)
            begin
                for (q = 0; q < KSIZE; q++)
                begin
                    wt  = weights[k][PIX_W*q +: PIX_W];
                    acc = acc + wt * win[k*KSIZE + q];
                end
            end
            due.conv_sum   = acc[SUM_W-1:0];
            due.frame_last = (r == h - 1) && (c == w - 1);
            sums_due.push_back(due);
        end
        if (c >= w - 1)
        begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        conv_result_t due;
        if (!rst_n)
        begin
            width_cfg  = SIZE_W'(MIN_SIZE);
            height_cfg = SIZE_W'(MIN_SIZE);
            weights    = '0;
            for (int i = 0; i < TAPS; i++)
                win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
            checked = 0;
            frames  = 0;
            sums_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:
                    begin
                        width_cfg = cfg_wdata[SIZE_W-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    CFG_IMAGE_HEIGHT:
                    begin
                        height_cfg = cfg_wdata[SIZE_W-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    CFG_KERNEL_ROW_TOP: weights[0] = cfg_wdata;
                    CFG_KERNEL_ROW_MID: weights[1] = cfg_wdata;
                    CFG_KERNEL_ROW_BOT: weights[2] = cfg_wdata;
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (sums_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with none expected, got sum %0d last %0b",
                             $time, res.conv_sum, res.frame_last);
                end
                else
                begin
                    due = sums_due.pop_front();
                    checked++;
                    if (due.frame_last)
                        frames++;
                    if (res.conv_sum !== due.conv_sum)
                    begin
                        errors++;
                        $display("%0t: conv_sum expected %0d, got %0d",
                                 $time, due.conv_sum, res.conv_sum);
                    end
                    if (res.frame_last !== due.frame_last)
                    begin
                        errors++;
                        $display("%0t: frame_last expected %0b, got %0b",
                                 $time, due.frame_last, res.frame_last);
                    end
                end
            end
            if (pix.valid && pix.ready)
                slide_and_sum(pix.pixel);
        end
        mismatches       <= errors;
        sums_outstanding <= sums_due.size();
        sums_checked     <= checked;
        frames_closed    <= frames;
    end

endmodule

// ===== dv/tb_conv3x3_valid_int8.sv =====
`timescale 1ns / 100ps
// tb_conv3x3_valid_int8: drives pixel frames and register writes into the convolution
// with bursty input and a stalling receiver; the verdict comes from c3v_sum_checker
// depends on c3v_pkg, the stream interfaces, conv3x3_valid_int8 and c3v_sum_checker

module tb_conv3x3_valid_int8;
    import c3v_pkg::*;

    localparam int MAX_W          = MAX_WIDTH_DEF;
    localparam int MAX_H          = MAX_HEIGHT_DEF;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_PIXELS  = 500;
    localparam int TALL_PIXELS    = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam krow_t  ALL_MIN_WEIGHTS = 24'h808080;
    localparam krow_t  ALL_MAX_WEIGHTS = 24'h7F7F7F;
    localparam pixel_t PIX_MIN         = 8'h80;
    localparam pixel_t PIX_MAX         = 8'h7F;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    c3v_pixel_if  pix ();
    c3v_result_if res ();

    int mismatches;
    int sums_outstanding;
    int sums_checked;
    int frames_closed;

    int frame_w = MIN_SIZE;
    int frame_h = MIN_SIZE;
    int frame_pos = 0;
    int burst_left = 0;
    int pixels_sent = 0;
    int reg_writes = 0;
    bit hold_request = 1'b0;

    always #6 clk = ~clk;

    conv3x3_valid_int8 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pix       (pix),
        .res       (res)
    );

    c3v_sum_checker sum_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .pix              (pix),
        .res              (res),
        .mismatches       (mismatches),
        .sums_outstanding (sums_outstanding),
        .sums_checked     (sums_checked),
        .frames_closed    (frames_closed)
    );

    function automatic int clamped(input logic [SIZE_W-1:0] v, input int limit);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // size in the low bits, random junk above
    function automatic logic [CFG_DATA_W-1:0] size_word(input logic [SIZE_W-1:0] sz);
        logic [CFG_DATA_W-1:0] d;
        d             = CFG_DATA_W'($urandom);
        d[SIZE_W-1:0] = sz;
        return d;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size(input int top);
        if ($urandom_range(0, 6) == 0)
            return SIZE_W'($urandom_range(0, MIN_SIZE - 1));
        return SIZE_W'($urandom_range(MIN_SIZE, top));
    endfunction

    function automatic krow_t random_weights();
        case ($urandom_range(0, 7))
            0: return ALL_MIN_WEIGHTS;
            1: return ALL_MAX_WEIGHTS;
            2: return '0;
            3: return '1;
            default: return krow_t'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        case ($urandom_range(0, 9))
            0: return PIX_MIN;
            1: return PIX_MAX;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_writes++;
        if (idx == CFG_IMAGE_WIDTH)
        begin
            frame_w   = clamped(data[SIZE_W-1:0], MAX_W);
            frame_pos = 0;
        end
        if (idx == CFG_IMAGE_HEIGHT)
        begin
            frame_h   = clamped(data[SIZE_W-1:0], MAX_H);
            frame_pos = 0;
        end
    endtask

    task automatic send_pixel(input pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 48);
        end
        pix.valid <= 1'b1;
        pix.pixel <= px;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        burst_left--;
        pixels_sent++;
        frame_pos = (frame_pos + 1 == frame_w * frame_h) ? 0 : frame_pos + 1;
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    // stop offering and let every expected sum come out, then let the pipe go quiet
    task automatic drain();
        pix.valid <= 1'b0;
        do
            @(posedge clk);
        while (sums_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: stretches of steady, half and sparse ready, plus one long hold
    initial
    begin : receiver
        int stretch_left;
        int style;
        stretch_left = 0;
        style        = 0;
        forever
        begin
            if (hold_request)
            begin
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
                stretch_left = 0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    style        = $urandom_range(0, 2);
                    stretch_left = $urandom_range(1, 64);
                end
                case (style)
                    0: res.ready <= 1'b1;
                    1: res.ready <= 1'($urandom_range(0, 1));
                    default: res.ready <= ($urandom_range(0, 3) == 0);
                endcase
                stretch_left--;
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pix.valid && pix.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int random_sent;
        int count;
        int frame_len;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_wdata <= '0;
        pix.valid <= 1'b0;
        pix.pixel <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // undersized words fall back to 3 by 3; largest positive sum
        write_reg(CFG_IMAGE_WIDTH, size_word('0));
        write_reg(CFG_IMAGE_HEIGHT, size_word(SIZE_W'(1)));
        write_reg(CFG_KERNEL_ROW_TOP, ALL_MIN_WEIGHTS);
        write_reg(CFG_KERNEL_ROW_MID, ALL_MIN_WEIGHTS);
        write_reg(CFG_KERNEL_ROW_BOT, ALL_MIN_WEIGHTS);
        repeat (9) send_pixel(PIX_MIN);

        // spare indexes mid-frame must not disturb it; new weights before the only sum
        repeat (4) send_pixel(PIX_MIN);
        drain();
        for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
            write_reg(CFG_IDX_W'(i), '1);
        repeat (4) send_pixel(PIX_MIN);
        drain();
        write_reg(CFG_KERNEL_ROW_TOP, ALL_MAX_WEIGHTS);
        write_reg(CFG_KERNEL_ROW_MID, ALL_MAX_WEIGHTS);
        write_reg(CFG_KERNEL_ROW_BOT, ALL_MAX_WEIGHTS);
        send_pixel(PIX_MIN);

        // long result stall while pixels keep coming
        drain();
        write_reg(CFG_IMAGE_WIDTH, size_word(SIZE_W'(8)));
        write_reg(CFG_IMAGE_HEIGHT, size_word(SIZE_W'(8)));
        write_reg(CFG_KERNEL_ROW_MID, random_weights());
        hold_request = 1'b1;
        send_random_pixels(2 * frame_w * frame_h);
        random_sent = 2 * frame_w * frame_h;

        // mostly whole frames with random content, some cut short
        while (random_sent < RANDOM_PIXELS)
        begin
            drain();
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IMAGE_WIDTH, size_word(random_size(12)));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IMAGE_HEIGHT, size_word(random_size(10)));
            for (int k = 0; k < KSIZE; k++)
            begin
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_IDX_W'(CFG_KERNEL_ROW_TOP + k), random_weights());
            end
            frame_len = frame_w * frame_h;
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, frame_len - 1);
            else
                count = frame_len - frame_pos + (($urandom_range(0, 1) == 0) ? 0 : frame_len);
            send_random_pixels(count);
            random_sent += count;
        end

        // oversized height word clamps to the maximum: the top part of one tall frame
        drain();
        write_reg(CFG_IMAGE_WIDTH, size_word(SIZE_W'(MIN_SIZE)));
        write_reg(CFG_IMAGE_HEIGHT, size_word('1));
        write_reg(CFG_KERNEL_ROW_TOP, random_weights());
        send_random_pixels(TALL_PIXELS);

        drain();
        $display("%0d pixel transfers and %0d register writes, sizes 3 up to a clamped height",
                 pixels_sent, reg_writes);
        $display("%0d sums checked over %0d complete frames, one long result stall",
                 sums_checked, frames_closed);
        if (mismatches == 0 && sums_outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/c3v_pkg.sv
hdl/c3v_stream_if.sv
hdl/c3v_linebuf.sv
hdl/c3v_window.sv
hdl/c3v_mac.sv
hdl/conv3x3_valid_int8.sv
dv/c3v_sum_checker.sv
dv/tb_conv3x3_valid_int8.sv
